// File: rtl/core/battery_charge_stage_controller_assert.svh
// Assertion macros used by the stage machine (bcsc_step) of the battery charge stage controller
`ifndef BATTERY_CHARGE_STAGE_CONTROLLER_ASSERT_SVH
`define BATTERY_CHARGE_STAGE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define BCSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcsc: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define BCSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcsc: next-cycle check failed");

`endif

// File: rtl/core/bcsc_pkg.sv
// Package: types and constants of the battery charge stage controller
`timescale 1ns / 1ps

package bcsc_pkg;

    localparam int VOLT_W  = 12;
    localparam int TEMP_W  = 8;
    localparam int CUT_W   = 11;
    localparam int ABOVE_W = 6;
    localparam int LOWC_W  = 8;
    localparam int MODE_W  = 3;
    localparam int OVR_W   = 2;

    typedef enum logic [1:0] {
        STG_WAIT_BACK = 2'd0,
        STG_WAIT_BATT = 2'd1,
        STG_CC        = 2'd2,
        STG_FULL      = 2'd3
    } t_stage;

    localparam logic [MODE_W-1:0] MODE_STANDBY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEALED  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AGM     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LITHIUM = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SIXV    = 3'd4;

    localparam logic [OVR_W-1:0] OVR_NONE = 2'd0;
    localparam logic [OVR_W-1:0] OVR_BATT = 2'd1;
    localparam logic [OVR_W-1:0] OVR_BACK = 2'd2;

    localparam logic [ABOVE_W-1:0] ABOVE_LIMIT     = 6'd30;
    localparam logic [ABOVE_W-1:0] ABOVE_MAX       = 6'd63;
    localparam logic [LOWC_W-1:0]  LOW_LIMIT_LONG  = 8'd200;
    localparam logic [LOWC_W-1:0]  LOW_LIMIT_SHORT = 8'd30;
    localparam logic [LOWC_W-1:0]  LOWC_MAX        = 8'd255;
    localparam logic [VOLT_W-1:0]  LEAD_LOW_LEVEL  = 12'd1250;
    localparam logic [VOLT_W-1:0]  SIXV_LOW_LEVEL  = 12'd500;
    localparam logic [CUT_W-1:0]   SIXV_CUTOFF     = 11'd700;

    localparam logic [CUT_W-1:0]   LEAD_BASE = 11'd1440;
    localparam logic [CUT_W-1:0]   LEAD_MAX  = 11'd1500;
    localparam logic [CUT_W-1:0]   LEAD_MIN  = 11'd1410;
    localparam logic [CUT_W:0]     LI_BASE   = 12'd1460;
    localparam logic [CUT_W:0]     LI_MAX    = 12'd1480;
    localparam logic [CUT_W:0]     LI_MIN    = 12'd1400;
    localparam logic [TEMP_W:0]    NOMINAL_TEMP = 9'd25;

    // -1.8/degC as 9/5: x/5 = (x * 6554) >> 15, exact for x below 1400
    localparam logic [3:0]  LEAD_MUL    = 4'd9;
    localparam logic [12:0] DIV5_RECIP  = 13'd6554;
    localparam int          DIV5_SHIFT  = 15;

    typedef struct packed {
        logic [VOLT_W-1:0]        battery_voltage;
        logic signed [TEMP_W-1:0] temperature;
        logic                     fault_present;
        logic [OVR_W-1:0]         stage_override;
    } t_item;

    typedef struct packed {
        logic [CUT_W-1:0] lead;
        logic [CUT_W-1:0] li;
    } t_cutoffs;

    typedef struct packed {
        logic       charge_enable;
        logic       high_current;
        logic [1:0] charge_stage;
    } t_result;

endpackage

// File: rtl/core/bcsc_if.sv
// Interfaces: input tick channel and result channel
`timescale 1ns / 1ps

interface bcsc_in_if;
    import bcsc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VOLT_W-1:0]        battery_voltage;
    logic signed [TEMP_W-1:0] temperature;
    logic                     fault_present;
    logic [OVR_W-1:0]         stage_override;

    modport source (
        output valid, battery_voltage, temperature, fault_present, stage_override,
        input  ready
    );
    modport sink (
        input  valid, battery_voltage, temperature, fault_present, stage_override,
        output ready
    );
endinterface

interface bcsc_out_if;
    logic       valid;
    logic       ready;
    logic       charge_enable;
    logic       high_current;
    logic [1:0] charge_stage;

    modport source (
        output valid, charge_enable, high_current, charge_stage,
        input  ready
    );
    modport sink (
        input  valid, charge_enable, high_current, charge_stage,
        output ready
    );
endinterface

// File: rtl/core/bcsc_cutoff.sv
// Temperature-compensated cutoff voltages for lead-acid and lithium modes
`timescale 1ns / 1ps

module bcsc_cutoff (
    input  logic signed [bcsc_pkg::TEMP_W-1:0] i_temperature,
    output bcsc_pkg::t_cutoffs                 o_cutoffs
);
    import bcsc_pkg::*;

    logic [TEMP_W:0]   d;
    logic              d_neg;
    logic [TEMP_W-1:0] mag;
    logic [CUT_W-1:0]  mag9;
    logic [23:0]       prod;
    logic [8:0]        q;
    logic [CUT_W-1:0]  lead_raw;
    logic [CUT_W:0]    li_raw;

    // d = temperature - 25, range -153..102
    assign d     = {i_temperature[TEMP_W-1], i_temperature} - NOMINAL_TEMP;
    assign d_neg = d[TEMP_W];
    assign mag   = d_neg ? TEMP_W'(-d) : TEMP_W'(d);

    // trunc(-18d/10) = -sign(d) * floor(9|d|/5)
    assign mag9 = CUT_W'(mag) * CUT_W'(LEAD_MUL);
    assign prod = 24'(mag9) * 24'(DIV5_RECIP);
    assign q    = 9'(prod >> DIV5_SHIFT);

    assign lead_raw = d_neg ? LEAD_BASE + CUT_W'(q) : LEAD_BASE - CUT_W'(q);
    assign li_raw   = d_neg ? LI_BASE + {2'b00, mag, 2'b00} : LI_BASE - {2'b00, mag, 2'b00};

    always_comb begin
        if (lead_raw > LEAD_MAX) begin
            o_cutoffs.lead = LEAD_MAX;
        end else if (lead_raw < LEAD_MIN) begin
            o_cutoffs.lead = LEAD_MIN;
        end else begin
            o_cutoffs.lead = lead_raw;
        end

        if (li_raw > LI_MAX) begin
            o_cutoffs.li = CUT_W'(LI_MAX);
        end else if (li_raw < LI_MIN) begin
            o_cutoffs.li = CUT_W'(LI_MIN);
        end else begin
            o_cutoffs.li = CUT_W'(li_raw);
        end
    end

endmodule

// File: rtl/core/bcsc_step.sv
// Stage machine with per-mode counters and latched cutoffs
`timescale 1ns / 1ps
`include "battery_charge_stage_controller_assert.svh"

module bcsc_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [bcsc_pkg::MODE_W-1:0]   i_mode,
    input  bcsc_pkg::t_item               i_item,
    input  bcsc_pkg::t_cutoffs            i_cutoffs,
    output bcsc_pkg::t_result             o_result
);
    import bcsc_pkg::*;

    t_stage              r_stage;
    logic [ABOVE_W-1:0]  r_sealed_above, r_agm_above, r_li_above, r_sixv_above;
    logic [LOWC_W-1:0]   r_sealed_low, r_agm_low, r_sixv_low;
    logic [CUT_W-1:0]    r_sealed_cut, r_agm_cut, r_li_cut;

    t_stage              stg_pre;
    logic                active;
    logic                has_low;
    logic [ABOVE_W-1:0]  cur_above;
    logic [LOWC_W-1:0]   cur_low;
    logic [CUT_W-1:0]    cur_cut;
    logic [CUT_W-1:0]    latch_cut;
    logic [VOLT_W-1:0]   low_level;
    logic [LOWC_W-1:0]   low_limit;

    t_stage              n_stage;
    logic [ABOVE_W-1:0]  n_above;
    logic [LOWC_W-1:0]   n_low;
    logic [CUT_W-1:0]    n_cut;

    logic                fire_back;
    logic                li_full_hold;
    logic                cc_or_full;

    // override first, then per-mode selection
    always_comb begin
        if (i_item.stage_override == OVR_BATT) begin
            stg_pre = STG_WAIT_BATT;
        end else if (i_item.stage_override == OVR_BACK) begin
            stg_pre = STG_WAIT_BACK;
        end else begin
            stg_pre = r_stage;
        end

        active    = 1'b1;
        has_low   = 1'b1;
        cur_above = '0;
        cur_low   = '0;
        cur_cut   = '0;
        latch_cut = '0;
        low_level = '0;
        low_limit = '0;
        case (i_mode)
            MODE_SEALED: begin
                cur_above = r_sealed_above;
                cur_low   = r_sealed_low;
                cur_cut   = r_sealed_cut;
                latch_cut = i_cutoffs.lead;
                low_level = LEAD_LOW_LEVEL;
                low_limit = LOW_LIMIT_LONG;
            end
            MODE_AGM: begin
                cur_above = r_agm_above;
                cur_low   = r_agm_low;
                cur_cut   = r_agm_cut;
                latch_cut = i_cutoffs.lead;
                low_level = LEAD_LOW_LEVEL;
                low_limit = LOW_LIMIT_SHORT;
            end
            MODE_LITHIUM: begin
                cur_above = r_li_above;
                cur_cut   = r_li_cut;
                latch_cut = i_cutoffs.li;
                has_low   = 1'b0;
            end
            MODE_SIXV: begin
                cur_above = r_sixv_above;
                cur_low   = r_sixv_low;
                cur_cut   = SIXV_CUTOFF;
                latch_cut = SIXV_CUTOFF;
                low_level = SIXV_LOW_LEVEL;
                low_limit = LOW_LIMIT_LONG;
            end
            default: begin
                active  = 1'b0;
                has_low = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_stage = stg_pre;
        n_above = cur_above;
        n_low   = cur_low;
        n_cut   = cur_cut;
        if (active) begin
            case (stg_pre)
                STG_WAIT_BACK: begin
                    n_above = '0;
                    n_low   = '0;
                end
                STG_WAIT_BATT: begin
                    n_cut = latch_cut;
                    if (!i_item.fault_present) begin
                        n_stage = STG_CC;
                        n_above = '0;
                        n_low   = '0;
                    end
                end
                STG_CC: begin
                    if (i_item.battery_voltage > {1'b0, cur_cut}) begin
                        if (cur_above > ABOVE_LIMIT) begin
                            n_stage = STG_FULL;
                        end
                        if (cur_above < ABOVE_MAX) begin
                            n_above = cur_above + 1'b1;
                        end
                    end
                end
                STG_FULL: begin
                    if (has_low && (i_item.battery_voltage < low_level)) begin
                        if (cur_low > low_limit) begin
                            n_stage = STG_CC;
                            n_low   = '0;
                            n_above = '0;
                        end else if (cur_low < LOWC_MAX) begin
                            n_low = cur_low + 1'b1;
                        end
                    end
                end
                default: begin
                    n_stage = stg_pre;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_result.charge_enable = 1'b0;
        o_result.high_current  = 1'b0;
        o_result.charge_stage  = n_stage;
        if (active) begin
            case (stg_pre)
                STG_CC: begin
                    o_result.charge_enable = 1'b1;
                    o_result.high_current  = 1'b1;
                end
                STG_FULL: begin
                    o_result.high_current = 1'b1;
                end
                default: begin
                    o_result.charge_enable = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage        <= STG_WAIT_BATT;
            r_sealed_above <= '0;
            r_sealed_low   <= '0;
            r_sealed_cut   <= '0;
            r_agm_above    <= '0;
            r_agm_low      <= '0;
            r_agm_cut      <= '0;
            r_li_above     <= '0;
            r_li_cut       <= '0;
            r_sixv_above   <= '0;
            r_sixv_low     <= '0;
        end else if (i_fire) begin
            r_stage <= n_stage;
            case (i_mode)
                MODE_SEALED: begin
                    r_sealed_above <= n_above;
                    r_sealed_low   <= n_low;
                    r_sealed_cut   <= n_cut;
                end
                MODE_AGM: begin
                    r_agm_above <= n_above;
                    r_agm_low   <= n_low;
                    r_agm_cut   <= n_cut;
                end
                MODE_LITHIUM: begin
                    r_li_above <= n_above;
                    r_li_cut   <= n_cut;
                end
                MODE_SIXV: begin
                    r_sixv_above <= n_above;
                    r_sixv_low   <= n_low;
                end
                default: begin
                end
            endcase
        end
    end

    assign fire_back    = i_fire && (i_item.stage_override == OVR_BACK);
    assign li_full_hold = i_fire && (i_mode == MODE_LITHIUM) && (r_stage == STG_FULL)
                          && (i_item.stage_override == OVR_NONE);
    assign cc_or_full   = (n_stage == STG_CC) || (n_stage == STG_FULL);

    `BCSC_ASSERT_NEXT(a_stage_hold, !i_fire, $stable(r_stage))
    `BCSC_ASSERT_NEXT(a_force_back, fire_back, r_stage == STG_WAIT_BACK)
    `BCSC_ASSERT_NEXT(a_li_stays_full, li_full_hold, r_stage == STG_FULL)
    `BCSC_ASSERT_SAME(a_enable_in_cc, i_fire && o_result.charge_enable, (stg_pre == STG_CC) && cc_or_full)

endmodule

// File: rtl/core/battery_charge_stage_controller.sv
// Top level: battery charge stage controller with input and result registers
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------------------
//  i_in    | in  | battery_voltage, temperature, fault_present, stage_override
//  o_out   | out | charge_enable, high_current, charge_stage
//  i_cfg_* | in  | battery_mode write (enable + data)
//
//  One transaction per cycle while o_out is ready; path: input register, then result register.
//  The stage and counters update in the single pass between input and result register.
//  Synchronous active-low reset: stage wait-battery, counters and cutoffs zero, mode standby.
//  A stalled result holds in the output register; input register keeps accepting when it drains.
`timescale 1ns / 1ps

module battery_charge_stage_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [bcsc_pkg::MODE_W-1:0] i_cfg_wr_data,
    bcsc_in_if.sink                     i_in,
    bcsc_out_if.source                  o_out
);
    import bcsc_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              fire;
    t_cutoffs          cutoffs;
    t_result           n_result;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;

    bcsc_cutoff u_cutoff (
        .i_temperature (r_in.temperature),
        .o_cutoffs     (cutoffs)
    );

    bcsc_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_mode    (r_mode),
        .i_item    (r_in),
        .i_cutoffs (cutoffs),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STANDBY;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.battery_voltage <= i_in.battery_voltage;
            r_in.temperature     <= i_in.temperature;
            r_in.fault_present   <= i_in.fault_present;
            r_in.stage_override  <= i_in.stage_override;
        end
        if (fire) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.charge_enable = r_out.charge_enable;
    assign o_out.high_current  = r_out.high_current;
    assign o_out.charge_stage  = r_out.charge_stage;

endmodule

// File: sim/battery_charge_stage_controller_test.sv
// Self-checking bench: random and directed ticks against a cycle-free stage predictor
`timescale 1ns / 1ps

module battery_charge_stage_controller_test;
    import bcsc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [OVR_W-1:0]  OVR_SPARE     = 2'd3;

    localparam int FULL_AFTER    = 30;
    localparam int ABOVE_SAT     = 63;
    localparam int LOW_SAT       = 255;
    localparam int SEALED_LOW_N  = 200;
    localparam int AGM_LOW_N     = 30;
    localparam int LEAD_LOW_V    = 1250;
    localparam int SIX_LOW_V     = 500;
    localparam int SIX_CUT_V     = 700;
    localparam int LEAD_CEIL     = 1500;
    localparam int LEAD_FLOOR    = 1410;
    localparam int LI_CEIL       = 1480;
    localparam int LI_FLOOR      = 1400;
    localparam int NEAR_CUT_LO   = 1395;
    localparam int PHASE_ITEMS   = 90;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [MODE_W-1:0] i_cfg_wr_data;

    bcsc_in_if  in_bus ();
    bcsc_out_if out_bus ();

    battery_charge_stage_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    // predictor state
    logic [MODE_W-1:0]  mode_m;
    t_stage             stage_m;
    logic [ABOVE_W-1:0] above_m [1:4];
    logic [LOWC_W-1:0]  low_m   [1:4];
    logic [CUT_W-1:0]   cut_m   [1:4];

    t_item   tick_queue  [$];
    t_result due_results [$];

    int          mismatches;
    int          pushed;
    int          hold_asked;
    int          hold_seen;
    int          hold_left;
    bit          no_gaps;
    int unsigned cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CUT_W-1:0] lead_cutoff(logic signed [TEMP_W-1:0] t);
        int v;
        v = 1440 + ((int'(t) - 25) * -18) / 10;
        if (v > LEAD_CEIL) v = LEAD_CEIL;
        if (v < LEAD_FLOOR) v = LEAD_FLOOR;
        return v[CUT_W-1:0];
    endfunction

    function automatic logic [CUT_W-1:0] li_cutoff(logic signed [TEMP_W-1:0] t);
        int v;
        v = 1460 - 4 * (int'(t) - 25);
        if (v > LI_CEIL) v = LI_CEIL;
        if (v < LI_FLOOR) v = LI_FLOOR;
        return v[CUT_W-1:0];
    endfunction

    function automatic t_result stage_step(t_item it);
        t_result          r;
        logic [CUT_W-1:0] cut_now;
        int               low_lvl;
        int               low_lim;
        r = '0;
        if (it.stage_override == OVR_BATT) stage_m = STG_WAIT_BATT;
        else if (it.stage_override == OVR_BACK) stage_m = STG_WAIT_BACK;
        if (mode_m >= MODE_SEALED && mode_m <= MODE_SIXV) begin
            low_lvl = (mode_m == MODE_SIXV) ? SIX_LOW_V : LEAD_LOW_V;
            low_lim = (mode_m == MODE_AGM) ? AGM_LOW_N : SEALED_LOW_N;
            case (stage_m)
                STG_WAIT_BACK: begin
                    above_m[mode_m] = '0;
                    low_m[mode_m]   = '0;
                end
                STG_WAIT_BATT: begin
                    if (mode_m == MODE_SEALED || mode_m == MODE_AGM)
                        cut_m[mode_m] = lead_cutoff(it.temperature);
                    else if (mode_m == MODE_LITHIUM)
                        cut_m[mode_m] = li_cutoff(it.temperature);
                    if (!it.fault_present) begin
                        stage_m         = STG_CC;
                        above_m[mode_m] = '0;
                        low_m[mode_m]   = '0;
                    end
                end
                STG_CC: begin
                    r.charge_enable = 1'b1;
                    r.high_current  = 1'b1;
                    cut_now = (mode_m == MODE_SIXV) ? CUT_W'(SIX_CUT_V) : cut_m[mode_m];
                    if (it.battery_voltage > cut_now) begin
                        if (above_m[mode_m] > FULL_AFTER) stage_m = STG_FULL;
                        if (above_m[mode_m] < ABOVE_SAT) above_m[mode_m]++;
                    end
                end
                default: begin
                    r.high_current = 1'b1;
                    if (mode_m != MODE_LITHIUM && it.battery_voltage < low_lvl) begin
                        if (low_m[mode_m] > low_lim) begin
                            stage_m         = STG_CC;
                            low_m[mode_m]   = '0;
                            above_m[mode_m] = '0;
                        end else if (low_m[mode_m] < LOW_SAT) begin
                            low_m[mode_m]++;
                        end
                    end
                end
            endcase
        end
        r.charge_stage = stage_m;
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin : drive_ticks
        t_item nxt;
        t_item took;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                took = {in_bus.battery_voltage, in_bus.temperature,
                        in_bus.fault_present, in_bus.stage_override};
                due_results.push_back(stage_step(took));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (tick_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 14)) begin
                    nxt = tick_queue.pop_front();
                    in_bus.valid           <= 1'b1;
                    in_bus.battery_voltage <= nxt.battery_voltage;
                    in_bus.temperature     <= nxt.temperature;
                    in_bus.fault_present   <= nxt.fault_present;
                    in_bus.stage_override  <= nxt.stage_override;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : watch_results
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = {out_bus.charge_enable, out_bus.high_current, out_bus.charge_stage};
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result en=%0b hc=%0b stage=%0d",
                             $time, got.charge_enable, got.high_current, got.charge_stage);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        $display({"%0t: expected en=%0b hc=%0b stage=%0d, ",
                                  "actual en=%0b hc=%0b stage=%0d"},
                                 $time, want.charge_enable, want.high_current, want.charge_stage,
                                 got.charge_enable, got.high_current, got.charge_stage);
                        mismatches++;
                    end
                end
            end
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= no_gaps || $urandom_range(0, 99) >= 14;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_tick(input int v, input int t, input bit f, input logic [OVR_W-1:0] o);
        t_item it;
        it.battery_voltage = v[VOLT_W-1:0];
        it.temperature     = t[TEMP_W-1:0];
        it.fault_present   = f;
        it.stage_override  = o;
        tick_queue.push_back(it);
        pushed++;
    endtask

    function automatic int pick_temp();
        if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 255)) - 128;
        return int'($urandom_range(0, 125)) - 40;
    endfunction

    // above: clear of any cutoff (or near it); below: under the recharge level (or near it)
    function automatic int pick_volt(logic [MODE_W-1:0] m, bit above);
        int cut_hi;
        int cut_lo;
        int low_lvl;
        bit near;
        if (m < MODE_SEALED || m > MODE_SIXV) return $urandom_range(0, 4095);
        cut_hi  = (m == MODE_SIXV) ? SIX_CUT_V : LEAD_CEIL;
        cut_lo  = (m == MODE_SIXV) ? SIX_CUT_V - 5 : NEAR_CUT_LO;
        low_lvl = (m == MODE_SIXV) ? SIX_LOW_V : LEAD_LOW_V;
        near    = ($urandom_range(0, 5) == 0);
        if (above)
            return near ? $urandom_range(cut_lo, cut_hi + 5) : $urandom_range(cut_hi + 1, 4095);
        return near ? $urandom_range(low_lvl - 4, low_lvl + 1) : $urandom_range(0, low_lvl - 1);
    endfunction

    task automatic charge_run(input logic [MODE_W-1:0] m);
        int n;
        if ($urandom_range(0, 3) == 0)
            push_tick(pick_volt(m, 1'b0), pick_temp(), 1'b1, OVR_BATT);
        push_tick(pick_volt(m, 1'b0), pick_temp(), 1'b0, OVR_BATT);
        n = $urandom_range(30, 50);
        repeat (n)
            push_tick(pick_volt(m, $urandom_range(0, 9) != 0), pick_temp(),
                      1'($urandom_range(0, 1)), OVR_NONE);
    endtask

    task automatic full_dwell(input logic [MODE_W-1:0] m);
        int n;
        if (m == MODE_SEALED || m == MODE_SIXV) n = SEALED_LOW_N + $urandom_range(5, 15);
        else if (m == MODE_AGM) n = AGM_LOW_N + $urandom_range(3, 9);
        else n = 15;
        repeat (n)
            push_tick(pick_volt(m, $urandom_range(0, 19) == 0), pick_temp(),
                      1'($urandom_range(0, 1)), OVR_NONE);
    endtask

    task automatic fill_phase(input logic [MODE_W-1:0] m);
        int start;
        int kind;
        int n;
        start = pushed;
        while (pushed - start < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                charge_run(m);
                if (kind <= 3) full_dwell(m);
            end else if (kind <= 7) begin
                push_tick(pick_volt(m, 1'b0), pick_temp(),
                          1'($urandom_range(0, 1)), OVR_BACK);
                n = $urandom_range(1, 5);
                repeat (n) push_tick(pick_volt(m, 1'b1), pick_temp(), 1'b0, OVR_NONE);
            end else begin
                n = $urandom_range(10, 20);
                repeat (n)
                    push_tick($urandom_range(0, 4095), int'($urandom_range(0, 255)) - 128,
                              1'($urandom_range(0, 1)),
                              OVR_W'($urandom_range(OVR_NONE, OVR_SPARE)));
            end
        end
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || in_bus.valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        mode_m = m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0] phase_modes [12];
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_wr_en            = 1'b0;
        i_cfg_wr_data          = MODE_STANDBY;
        in_bus.valid           = 1'b0;
        in_bus.battery_voltage = '0;
        in_bus.temperature     = '0;
        in_bus.fault_present   = 1'b0;
        in_bus.stage_override  = OVR_NONE;
        out_bus.ready          = 1'b0;
        mode_m                 = MODE_STANDBY;
        stage_m                = STG_WAIT_BATT;
        for (int i = 1; i <= 4; i++) begin
            above_m[i] = '0;
            low_m[i]   = '0;
            cut_m[i]   = '0;
        end
        phase_modes = '{MODE_AGM, MODE_LITHIUM, MODE_SIXV, MODE_STANDBY, MODE_SEALED,
                        MODE_SPARE_HI, MODE_SIXV, MODE_AGM, MODE_SEALED, MODE_LITHIUM,
                        MODE_SPARE_LO, MODE_AGM};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sealed lead: clamps at both temperature extremes, truncation, compare at the cutoff
        write_mode(MODE_SEALED);
        push_tick(0, -128, 1'b1, OVR_BATT);
        push_tick(4095, 127, 1'b1, OVR_NONE);
        push_tick(1411, 24, 1'b0, OVR_NONE);
        push_tick(1441, 26, 1'b0, OVR_NONE);
        push_tick(1442, 26, 1'b1, OVR_NONE);
        push_tick(4095, 85, 1'b0, OVR_SPARE);
        push_tick(0, -40, 1'b0, OVR_BACK);
        push_tick(4095, 0, 1'b0, OVR_NONE);
        push_tick(1300, 35, 1'b0, OVR_BATT);
        push_tick(1300, 35, 1'b0, OVR_NONE);
        push_tick(1440, 25, 1'b0, OVR_BATT);
        push_tick(1441, 25, 1'b0, OVR_NONE);
        push_tick(0, 19, 1'b1, OVR_BATT);
        wait_idle();
        write_mode(MODE_LITHIUM);
        push_tick(0, -128, 1'b0, OVR_BATT);
        push_tick(1481, 127, 1'b0, OVR_NONE);
        wait_idle();
        write_mode(MODE_STANDBY);
        push_tick(4095, 0, 1'b0, OVR_BACK);
        push_tick(0, 25, 1'b0, OVR_NONE);
        wait_idle();
        write_mode(MODE_SPARE_HI);
        push_tick(4095, 85, 1'b1, OVR_BATT);
        wait_idle();
        write_mode(MODE_SIXV);
        push_tick(701, 25, 1'b0, OVR_BATT);
        push_tick(701, 25, 1'b0, OVR_NONE);
        push_tick(700, 25, 1'b0, OVR_NONE);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            write_mode(phase_modes[p]);
            no_gaps <= (p == 4);
            fill_phase(phase_modes[p]);
            if (p == 1 || p == 8) hold_asked <= hold_asked + 1;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
